### hdl/outcode_line_clipper_top_assert.svh
// assertion macros for the outcode line clipper top level
// used by outcode_line_clipper_top.sv only
`ifndef OUTCODE_LINE_CLIPPER_TOP_ASSERT_SVH
`define OUTCODE_LINE_CLIPPER_TOP_ASSERT_SVH

// implication checked every clock outside reset
`define OLC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication checked every clock outside reset
`define OLC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/olc_pkg.sv
// shared types, constants and codes for the outcode line clipper
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package olc_pkg;
   localparam int COORD_BITS_DEF = 16;
   localparam int ROUND_LIMIT = 8;
   localparam int ROUND_BITS = 4;

   localparam logic [3:0] CODE_LEFT   = 4'b0001;
   localparam logic [3:0] CODE_RIGHT  = 4'b0010;
   localparam logic [3:0] CODE_BOTTOM = 4'b0100;
   localparam logic [3:0] CODE_TOP    = 4'b1000;

   localparam logic [1:0] CSR_X_MIN = 2'd0;
   localparam logic [1:0] CSR_X_MAX = 2'd1;
   localparam logic [1:0] CSR_Y_MIN = 2'd2;
   localparam logic [1:0] CSR_Y_MAX = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_MULT,
      ST_DIV,
      ST_UPDATE,
      ST_DONE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;     // capture input beat
      logic mult;     // form product and divisor
      logic div_step; // one restoring division step
      logic update;   // write the moved endpoint back
      logic finish;   // load the result register
      logic vis;      // visible flag for finish
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [3:0] code_start;
      logic [3:0] code_end;
      logic       div_done;
   } status_type;
endpackage
`default_nettype wire

### hdl/olc_if.sv
// valid/ready channel interface with a generic payload
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none
interface olc_if #(
   parameter int WIDTH = 64
) ();
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

### hdl/olc_ctrl.sv
// controller state machine: rounds of outcode test, multiply and divide
// depends on olc_pkg
`timescale 1ns / 1ps
`default_nettype none
module olc_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_ready,
   output logic                    out_valid,
   input  wire logic               out_ready,
   input  wire olc_pkg::status_type status,
   output olc_pkg::cmd_type         cmd
);
   import olc_pkg::*;

   state_type            state_ff, state_in;
   logic [ROUND_BITS-1:0] round_ff, round_in;
   logic                 valid_ff, valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         round_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         round_ff <= round_in;
         valid_ff <= valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      round_in = round_ff;
      valid_in = valid_ff;
      cmd      = '0;
      in_ready = 1'b0;
      if (valid_ff && out_ready) begin
         valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               cmd.load = 1'b1;
               round_in = '0;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if ((status.code_start | status.code_end) == 4'b0000) begin
               cmd.vis  = 1'b1;
               state_in = ST_DONE;
            end else if ((status.code_start & status.code_end) != 4'b0000 ||
                         round_ff == ROUND_BITS'(ROUND_LIMIT)) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_MULT;
            end
            // remember the verdict by re-evaluating in done; outcodes hold
         end
         ST_MULT: begin
            cmd.mult = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_done) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            round_in   = round_ff + 1'b1;
            state_in   = ST_CHECK;
         end
         ST_DONE: begin
            // outcodes are unchanged since check, so the verdict is recomputed
            if (!valid_ff || out_ready) begin
               cmd.finish = 1'b1;
               cmd.vis    = ((status.code_start | status.code_end) == 4'b0000);
               valid_in   = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign out_valid = valid_ff;
endmodule
`default_nettype wire

### hdl/olc_dpath.sv
// datapath: window registers, endpoints, outcodes, multiplier and serial divider
// depends on olc_pkg
`timescale 1ns / 1ps
`default_nettype none
module olc_dpath #(
   parameter int COORD_BITS = olc_pkg::COORD_BITS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_write,
   input  wire logic [1:0]                   csr_index,
   input  wire logic [COORD_BITS-1:0]        csr_data,
   input  wire logic signed [COORD_BITS-1:0] in_sx,
   input  wire logic signed [COORD_BITS-1:0] in_sy,
   input  wire logic signed [COORD_BITS-1:0] in_ex,
   input  wire logic signed [COORD_BITS-1:0] in_ey,
   input  wire olc_pkg::cmd_type              cmd,
   output olc_pkg::status_type                status,
   output logic                              res_vis,
   output logic signed [COORD_BITS-1:0]      res_sx,
   output logic signed [COORD_BITS-1:0]      res_sy,
   output logic signed [COORD_BITS-1:0]      res_ex,
   output logic signed [COORD_BITS-1:0]      res_ey
);
   import olc_pkg::*;

   localparam int W  = COORD_BITS;
   localparam int DW = COORD_BITS + 1;     // difference width, magnitude fits W bits
   localparam int PW = 2 * COORD_BITS;     // product magnitude
   localparam int CW = $clog2(PW + 1);

   typedef logic signed [W-1:0] coord_type;

   coord_type xmin_ff, xmax_ff, ymin_ff, ymax_ff;
   coord_type sx_ff, sy_ff, ex_ff, ey_ff;
   coord_type ox_ff, oy_ff, oex_ff, oey_ff;
   coord_type a1_ff, edge_ff;
   logic      side_ff, horiz_ff, neg_ff;
   logic [PW-1:0] num_ff;
   logic [W:0]    den_ff;
   logic [PW-1:0] quo_ff;
   logic [W:0]    rem_ff;
   logic [CW-1:0] cnt_ff;
   logic          vis_ff;
   coord_type     rsx_ff, rsy_ff, rex_ff, rey_ff;

   function automatic logic [3:0] outcode(coord_type x, coord_type y,
      coord_type x0, coord_type x1, coord_type y0, coord_type y1);
      logic [3:0] c;
      c = 4'b0000;
      if (x < x0) c = c | CODE_LEFT;
      else if (x > x1) c = c | CODE_RIGHT;
      if (y < y0) c = c | CODE_BOTTOM;
      else if (y > y1) c = c | CODE_TOP;
      return c;
   endfunction

   logic [3:0] cs, ce, oc;
   assign cs = outcode(sx_ff, sy_ff, xmin_ff, xmax_ff, ymin_ff, ymax_ff);
   assign ce = outcode(ex_ff, ey_ff, xmin_ff, xmax_ff, ymin_ff, ymax_ff);
   assign oc = (cs != 4'b0000) ? cs : ce;

   // operand selection for the round
   logic      horiz;
   coord_type edge_sel, a1, a2, b1, b2;
   always_comb begin
      horiz = 1'b0;
      edge_sel = xmin_ff;
      if ((oc & CODE_LEFT) != 4'b0000) begin
         edge_sel = xmin_ff;
      end else if ((oc & CODE_RIGHT) != 4'b0000) begin
         edge_sel = xmax_ff;
      end else if ((oc & CODE_BOTTOM) != 4'b0000) begin
         horiz = 1'b1; edge_sel = ymin_ff;
      end else begin
         horiz = 1'b1; edge_sel = ymax_ff;
      end
      a1 = horiz ? sx_ff : sy_ff;
      a2 = horiz ? ex_ff : ey_ff;
      b1 = horiz ? sy_ff : sx_ff;
      b2 = horiz ? ey_ff : ex_ff;
   end

   logic signed [DW-1:0] p_d, n_d, d_d;
   logic [W:0] p_m, n_m, d_m;
   assign p_d = DW'(a2) - DW'(a1);
   assign n_d = DW'(edge_sel) - DW'(b1);
   assign d_d = DW'(b2) - DW'(b1);
   assign p_m = p_d[DW-1] ? (W+1)'(-p_d) : (W+1)'(p_d);
   assign n_m = n_d[DW-1] ? (W+1)'(-n_d) : (W+1)'(n_d);
   assign d_m = d_d[DW-1] ? (W+1)'(-d_d) : (W+1)'(d_d);

   // restoring division step
   logic [W+1:0] trial;
   assign trial = {rem_ff, num_ff[PW-1]} - {1'b0, den_ff};

   coord_type interp;
   logic [W-1:0] q_lo;
   assign q_lo = quo_ff[W-1:0];
   assign interp = neg_ff ? (a1_ff - coord_type'(q_lo)) : (a1_ff + coord_type'(q_lo));

   always_ff @(posedge clock) begin
      if (reset) begin
         xmin_ff <= '0;
         xmax_ff <= coord_type'({1'b0, {(W-1){1'b1}}});
         ymin_ff <= '0;
         ymax_ff <= coord_type'({1'b0, {(W-1){1'b1}}});
         cnt_ff  <= '0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_X_MIN: xmin_ff <= csr_data;
               CSR_X_MAX: xmax_ff <= csr_data;
               CSR_Y_MIN: ymin_ff <= csr_data;
               CSR_Y_MAX: ymax_ff <= csr_data;
               default: ;
            endcase
         end
         if (cmd.mult) begin
            cnt_ff <= CW'(PW);
         end else if (cmd.div_step && cnt_ff != '0) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sx_ff <= in_sx; sy_ff <= in_sy; ex_ff <= in_ex; ey_ff <= in_ey;
         ox_ff <= in_sx; oy_ff <= in_sy; oex_ff <= in_ex; oey_ff <= in_ey;
      end
      if (cmd.mult) begin
         // product of two magnitudes, each below 2^W
         num_ff   <= PW'(p_m * n_m);
         den_ff   <= d_m;
         quo_ff   <= '0;
         rem_ff   <= '0;
         a1_ff    <= a1;
         edge_ff  <= edge_sel;
         side_ff  <= (cs == 4'b0000);
         horiz_ff <= horiz;
         neg_ff   <= (p_d[DW-1] != n_d[DW-1]) ^ d_d[DW-1];
      end
      if (cmd.div_step && cnt_ff != '0) begin
         num_ff <= {num_ff[PW-2:0], 1'b0};
         if (!trial[W+1]) begin
            rem_ff <= trial[W:0];
            quo_ff <= {quo_ff[PW-2:0], 1'b1};
         end else begin
            rem_ff <= {rem_ff[W-1:0], num_ff[PW-1]};
            quo_ff <= {quo_ff[PW-2:0], 1'b0};
         end
      end
      if (cmd.update) begin
         // a zero divisor keeps a1 as the moved coordinate instead of the quotient
         if (!side_ff) begin
            if (horiz_ff) begin
               sy_ff <= edge_ff; sx_ff <= (den_ff == '0) ? a1_ff : interp;
            end else begin
               sx_ff <= edge_ff; sy_ff <= (den_ff == '0) ? a1_ff : interp;
            end
         end else begin
            if (horiz_ff) begin
               ey_ff <= edge_ff; ex_ff <= (den_ff == '0) ? a1_ff : interp;
            end else begin
               ex_ff <= edge_ff; ey_ff <= (den_ff == '0) ? a1_ff : interp;
            end
         end
      end
      if (cmd.finish) begin
         vis_ff <= cmd.vis;
         rsx_ff <= cmd.vis ? sx_ff : ox_ff;
         rsy_ff <= cmd.vis ? sy_ff : oy_ff;
         rex_ff <= cmd.vis ? ex_ff : oex_ff;
         rey_ff <= cmd.vis ? ey_ff : oey_ff;
      end
   end

   // quotient bits beyond W only matter through wrap, which truncation gives
   assign status.code_start = cs;
   assign status.code_end   = ce;
   assign status.div_done   = (cnt_ff == CW'(1));
   assign res_vis = vis_ff;
   assign res_sx  = rsx_ff;
   assign res_sy  = rsy_ff;
   assign res_ex  = rex_ff;
   assign res_ey  = rey_ff;
endmodule
`default_nettype wire

### hdl/outcode_line_clipper_top.sv
// Outcode line clipper: clips one segment per beat against a window
// held in four registers. Each segment runs up to eight rounds of one multiply
// and a 2*COORD_BITS-step restoring division; accepted or trivially rejected
// segments need no round. One segment is in flight at a time; the result
// register lets the next segment start while a result waits.
// depends on olc_pkg, olc_if, olc_ctrl, olc_dpath and the assertion header
`timescale 1ns / 1ps
`default_nettype none
`include "outcode_line_clipper_top_assert.svh"
module outcode_line_clipper_top #(
   parameter int COORD_BITS = olc_pkg::COORD_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_write,
   input  wire logic [1:0]            csr_index,
   input  wire logic [COORD_BITS-1:0] csr_data,
   olc_if.sink                        req,
   olc_if.source                      rsp
);
   import olc_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       in_ready, out_valid, res_vis;
   logic signed [COORD_BITS-1:0] res_sx, res_sy, res_ex, res_ey;

   // req payload: start_x, start_y, end_x, end_y from low bits up
   olc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req.valid),
      .in_ready  (in_ready),
      .out_valid (out_valid),
      .out_ready (rsp.ready),
      .status    (status),
      .cmd       (cmd)
   );

   olc_dpath #(.COORD_BITS(COORD_BITS)) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .in_sx     (req.payload[COORD_BITS-1:0]),
      .in_sy     (req.payload[2*COORD_BITS-1:COORD_BITS]),
      .in_ex     (req.payload[3*COORD_BITS-1:2*COORD_BITS]),
      .in_ey     (req.payload[4*COORD_BITS-1:3*COORD_BITS]),
      .cmd       (cmd),
      .status    (status),
      .res_vis   (res_vis),
      .res_sx    (res_sx),
      .res_sy    (res_sy),
      .res_ex    (res_ex),
      .res_ey    (res_ey)
   );

   assign req.ready   = in_ready;
   assign rsp.valid   = out_valid;
   // rsp payload: visible, then the four coordinates
   assign rsp.payload = {res_ey, res_ex, res_sy, res_sx, res_vis};

   `OLC_ASSERT_NEXT(a_finish_valid, clock, reset, cmd.finish, rsp.valid, "result not raised")
   `OLC_ASSERT_IMPL(a_one_cmd, clock, reset, 1'b1,
      $onehot0({cmd.load, cmd.mult, cmd.div_step, cmd.update, cmd.finish}), "command overlap")
   `OLC_ASSERT_IMPL(a_load_ready, clock, reset, cmd.load, req.ready && req.valid, "load w/o beat")
endmodule
`default_nettype wire

### tb/sv/outcode_line_clipper_top_tb.sv
// self-checking testbench for the outcode line clipper: segments go in on req,
// results are predicted here and checked beat by beat on rsp
// depends on olc_pkg, olc_if and outcode_line_clipper_top
`timescale 1ns / 1ps
module outcode_line_clipper_top_tb;
   import olc_pkg::*;

   localparam int W = 16;
   localparam int CYCLE_LIMIT = 3000000;
   localparam int DRAIN_CYCLES = 400;

   // start_x sits in the low bits of the req beat
   typedef struct packed {
      logic signed [W-1:0] ey;
      logic signed [W-1:0] ex;
      logic signed [W-1:0] sy;
      logic signed [W-1:0] sx;
   } segment_t;

   // visible sits in bit 0 of the rsp beat
   typedef struct packed {
      logic signed [W-1:0] ey;
      logic signed [W-1:0] ex;
      logic signed [W-1:0] sy;
      logic signed [W-1:0] sx;
      logic                visible;
   } clip_result_t;

   logic          clock;
   logic          reset;
   logic          csr_write;
   logic [1:0]    csr_index;
   logic [W-1:0]  csr_data;

   olc_if #(.WIDTH(4*W)) req_if ();
   olc_if #(.WIDTH(4*W+1)) rsp_if ();

   outcode_line_clipper_top #(.COORD_BITS(W)) uut (
      .clock(clock),
      .reset(reset),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .req(req_if),
      .rsp(rsp_if)
   );

   // local copy of the clip window
   longint win_x_min, win_x_max, win_y_min, win_y_max;
   clip_result_t pending_clips[$];
   int error_count;
   int cycle_count;
   bit no_idle;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      csr_write = 1'b0;
      csr_index = CSR_X_MIN;
      csr_data = '0;
      req_if.valid = 1'b0;
      req_if.payload = '0;
      rsp_if.ready = 1'b0;
   end

   function automatic longint wrap_coord(longint v);
      logic signed [W-1:0] t;
      t = v[W-1:0];
      return longint'(t);
   endfunction

   function automatic logic [3:0] region_code(longint x, longint y);
      logic [3:0] c;
      c = '0;
      if (x < win_x_min) c |= CODE_LEFT;
      else if (x > win_x_max) c |= CODE_RIGHT;
      if (y < win_y_min) c |= CODE_BOTTOM;
      else if (y > win_y_max) c |= CODE_TOP;
      return c;
   endfunction

   // a1 + (a2-a1)*(bound-b1)/(b2-b1), truncated toward zero
   function automatic longint cross_point(longint a1, longint a2, longint b1, longint b2,
                                          longint bound);
      longint p, n, d, q;
      bit neg;
      p = a2 - a1;
      n = bound - b1;
      d = b2 - b1;
      q = 0;
      neg = (p < 0) != (n < 0);
      if (d != 0) begin
         q = ((p < 0) ? -p : p) * ((n < 0) ? -n : n) / ((d < 0) ? -d : d);
         if (d < 0) neg = !neg;
      end
      return wrap_coord(a1 + (neg ? -q : q));
   endfunction

   function automatic clip_result_t clip_segment(segment_t s);
      longint x1, y1, x2, y2, nx, ny;
      logic [3:0] c1, c2, oc;
      bit vis;
      clip_result_t r;
      x1 = s.sx; y1 = s.sy; x2 = s.ex; y2 = s.ey;
      c1 = region_code(x1, y1);
      c2 = region_code(x2, y2);
      vis = 1'b0;
      for (int round = 0; ; round++) begin
         if ((c1 | c2) == 4'b0) begin
            vis = 1'b1;
            break;
         end
         if ((c1 & c2) != 4'b0 || round == ROUND_LIMIT) break;
         oc = (c1 != 4'b0) ? c1 : c2;
         if (oc & CODE_LEFT) begin
            nx = win_x_min;
            ny = cross_point(y1, y2, x1, x2, win_x_min);
         end else if (oc & CODE_RIGHT) begin
            nx = win_x_max;
            ny = cross_point(y1, y2, x1, x2, win_x_max);
         end else if (oc & CODE_BOTTOM) begin
            ny = win_y_min;
            nx = cross_point(x1, x2, y1, y2, win_y_min);
         end else begin
            ny = win_y_max;
            nx = cross_point(x1, x2, y1, y2, win_y_max);
         end
         if (c1 == oc) begin
            x1 = nx; y1 = ny; c1 = region_code(x1, y1);
         end else begin
            x2 = nx; y2 = ny; c2 = region_code(x2, y2);
         end
      end
      r.visible = vis;
      if (vis) begin
         r.sx = x1[W-1:0]; r.sy = y1[W-1:0]; r.ex = x2[W-1:0]; r.ey = y2[W-1:0];
      end else begin
         r.sx = s.sx; r.sy = s.sy; r.ex = s.ex; r.ey = s.ey;
      end
      return r;
   endfunction

   task automatic report_mismatch(string field, longint got, longint want);
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, field, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_if.ready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 37);
   end

   // compares each result beat with the oldest prediction
   always @(posedge clock) begin
      clip_result_t got, want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = rsp_if.payload;
         if (pending_clips.size() == 0) begin
            $display("[%0t] result beat with no segment outstanding", $time);
            error_count++;
         end else begin
            want = pending_clips.pop_front();
            if (got.visible !== want.visible) report_mismatch("visible", got.visible,
                                                              want.visible);
            if (got.sx !== want.sx) report_mismatch("clipped_start_x", got.sx, want.sx);
            if (got.sy !== want.sy) report_mismatch("clipped_start_y", got.sy, want.sy);
            if (got.ex !== want.ex) report_mismatch("clipped_end_x", got.ex, want.ex);
            if (got.ey !== want.ey) report_mismatch("clipped_end_y", got.ey, want.ey);
         end
      end
   end

   task automatic send_segment(segment_t s);
      if (!no_idle && $urandom_range(0, 99) < 37) begin
         @(negedge clock) req_if.valid <= 1'b0;
         repeat ($urandom_range(0, 4)) @(negedge clock);
      end
      @(negedge clock);
      req_if.valid <= 1'b1;
      req_if.payload <= s;
      do @(posedge clock); while (!req_if.ready);
      pending_clips.insert(pending_clips.size(), clip_segment(s));
   endtask

   task automatic wait_idle();
      @(negedge clock) req_if.valid <= 1'b0;
      while (pending_clips.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, longint value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value[W-1:0];
      @(negedge clock) csr_write <= 1'b0;
      case (idx)
         CSR_X_MIN: win_x_min = wrap_coord(value);
         CSR_X_MAX: win_x_max = wrap_coord(value);
         CSR_Y_MIN: win_y_min = wrap_coord(value);
         default:   win_y_max = wrap_coord(value);
      endcase
   endtask

   task automatic set_window(longint xl, longint xh, longint yl, longint yh);
      write_reg(CSR_X_MIN, xl);
      write_reg(CSR_X_MAX, xh);
      write_reg(CSR_Y_MIN, yl);
      write_reg(CSR_Y_MAX, yh);
   endtask

   task automatic send_coords(longint a, longint b, longint c, longint d);
      segment_t s;
      s.sx = a[W-1:0]; s.sy = b[W-1:0]; s.ex = c[W-1:0]; s.ey = d[W-1:0];
      send_segment(s);
   endtask

   function automatic longint pick_coord(longint lo, longint hi);
      longint a, b, v;
      int sel;
      a = (lo < hi) ? lo : hi;
      b = (lo < hi) ? hi : lo;
      sel = $urandom_range(0, 99);
      if (sel < 12) return longint'($signed(W'($urandom)));
      if (sel < 20) begin
         case ($urandom_range(0, 3))
            0: return -32768;
            1: return 32767;
            2: return lo;
            default: return hi;
         endcase
      end
      v = a - 200 + longint'($urandom_range(0, 400 + 2 * int'((b - a) >> 2)))
          + ((b - a) >> 1) - ((b - a) >> 2);
      if ($urandom_range(0, 1)) v = a + longint'($urandom % (b - a + 401)) - 200;
      if (v < -32768) v = -32768;
      if (v > 32767) v = 32767;
      return v;
   endfunction

   task automatic random_segments(int count);
      for (int i = 0; i < count; i++)
         send_coords(pick_coord(win_x_min, win_x_max), pick_coord(win_y_min, win_y_max),
                     pick_coord(win_x_min, win_x_max), pick_coord(win_y_min, win_y_max));
   endtask

   // reset window: everything in the positive quadrant
   task automatic test_reset_window();
      win_x_min = 0; win_x_max = 32767; win_y_min = 0; win_y_max = 32767;
      send_coords(10, 20, 30000, 32767);
      send_coords(-5, 100, 500, -300);
      send_coords(-32768, -32768, -1, -1);
      wait_idle();
   endtask

   task automatic test_directed();
      set_window(-100, 200, -50, 150);
      send_coords(0, 0, 100, 100);            // fully inside
      send_coords(-100, -50, 200, 150);       // corners, on the edges
      send_coords(-300, 0, -200, 100);        // trivially rejected left
      send_coords(300, 0, 400, 100);          // trivially rejected right
      send_coords(0, -300, 100, -60);         // trivially rejected bottom
      send_coords(0, 400, 100, 160);          // trivially rejected top
      send_coords(-500, 37, 50, 41);          // crosses left
      send_coords(50, 41, 900, -7);           // crosses right
      send_coords(13, -900, 27, 100);         // crosses bottom
      send_coords(27, 100, -3, 999);          // crosses top
      send_coords(-400, -400, 500, 500);      // both ends outside, diagonal
      send_coords(-400, 300, 100, -300);      // both outside, needs several rounds
      send_coords(-250, 140, 10, 400);        // misses the corner
      send_coords(-32768, -32768, 32767, 32767);
      send_coords(32767, -32768, -32768, 32767);
      send_coords(-32768, 0, 32767, 0);       // horizontal
      send_coords(0, -32768, 0, 32767);       // vertical
      send_coords(5, 5, 5, 5);                // single point inside
      send_coords(-999, 5, -999, 5);          // single point outside
      wait_idle();
   endtask

   task automatic test_window_extremes();
      set_window(-32768, 32767, -32768, 32767);
      send_coords(-32768, 32767, 32767, -32768);
      random_segments(20);
      wait_idle();
      set_window(0, 0, 0, 0);                 // single pixel window
      send_coords(-10, -10, 10, 10);
      send_coords(-10, 3, 10, -3);
      random_segments(20);
      wait_idle();
      set_window(32767, -32768, 32767, -32768); // inverted, all points outside
      send_coords(0, 0, 10, 10);
      send_coords(-32768, -32768, 32767, 32767);
      random_segments(20);
      wait_idle();
      set_window(100, -100, -20, 20);         // inverted x only
      send_coords(-300, 0, 300, 5);
      random_segments(30);
      wait_idle();
   endtask

   task automatic test_random();
      longint a, b, c, d;
      for (int phase = 0; phase < 7; phase++) begin
         a = longint'($signed(W'($urandom)));
         b = longint'($signed(W'($urandom)));
         c = longint'($signed(W'($urandom)));
         d = longint'($signed(W'($urandom)));
         if (phase % 3 != 2) begin
            if (a > b) begin a = a ^ b; b = a ^ b; a = a ^ b; end
            if (c > d) begin c = c ^ d; d = c ^ d; c = c ^ d; end
         end
         if (phase == 1) begin
            a = -200 + $urandom_range(0, 100); b = a + $urandom_range(0, 400);
            c = -200 + $urandom_range(0, 100); d = c + $urandom_range(0, 400);
         end
         set_window(a, b, c, d);
         no_idle = (phase == 4);
         random_segments(120);
         // hold off until the block has drained, then continue
         if (phase == 3) wait_idle();
         random_segments(130);
         no_idle = 1'b0;
         wait_idle();
      end
   endtask

   initial begin
      error_count = 0;
      cycle_count = 0;
      no_idle = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      test_reset_window();
      test_directed();
      test_window_extremes();
      test_random();
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_clips.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
